// ----- hw/rtl/oli_pkg.sv -----
package oli_pkg;

    // Field widths of the request and result beats.
    localparam int unsigned KIND_W      = 3;
    localparam int unsigned POS_W       = 7;
    localparam int unsigned DATA_W      = 32;
    localparam int unsigned STATUS_W    = 2;
    localparam int unsigned COUNT_OUT_W = 7;

    // Packed beat widths, rounded up to whole bytes.
    localparam int unsigned S_FIELDS_W = KIND_W + POS_W + DATA_W;
    localparam int unsigned M_FIELDS_W = STATUS_W + DATA_W + COUNT_OUT_W;
    localparam int unsigned S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int unsigned M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    localparam int unsigned DEPTH_DEFAULT = 64;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT    = 3'd0,
        KIND_DELETE    = 3'd1,
        KIND_APPEND    = 3'd2,
        KIND_OVERWRITE = 3'd3,
        KIND_READ      = 3'd4
    } kind_e_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_FULL  = 2'd2
    } status_e_t;

    // What every cell of the row does in the cycle of an accepted request.
    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_SHIFT_UP   = 2'd1,
        CELL_SHIFT_DOWN = 2'd2,
        CELL_WRITE      = 2'd3
    } cell_op_e_t;

    typedef struct packed {
        cell_op_e_t              op;
        logic [DATA_W-1:0]       value;
    } cell_ctrl_t;

endpackage

// ----- hw/rtl/oli_cell.sv -----
module oli_cell
    import oli_pkg::*;
#(
    parameter int unsigned IDX   = 0,
    parameter int unsigned CMP_W = 7
) (
    input  logic              aclk,
    input  cell_ctrl_t        ctrl_i,
    input  logic [CMP_W-1:0]  pos_i,
    input  logic [DATA_W-1:0] left_i,
    input  logic [DATA_W-1:0] right_i,
    output logic [DATA_W-1:0] word_o,
    output logic [DATA_W-1:0] rd_o
);

    localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(IDX);

    logic [DATA_W-1:0] word_reg;
    logic [DATA_W-1:0] word_next;
    logic              at_pos;
    logic              above_pos;

    assign at_pos    = (pos_i == MY_IDX);
    assign above_pos = (MY_IDX > pos_i);

    // Insert moves the slot and every entry above it one cell up; delete pulls
    // the slot and everything above it one cell down.
    always_comb begin
        word_next = word_reg;
        unique case (ctrl_i.op)
            CELL_HOLD: begin
                word_next = word_reg;
            end
            CELL_SHIFT_UP: begin
                if (above_pos) begin
                    word_next = left_i;
                end else if (at_pos) begin
                    word_next = ctrl_i.value;
                end
            end
            CELL_SHIFT_DOWN: begin
                if (above_pos || at_pos) begin
                    word_next = right_i;
                end
            end
            CELL_WRITE: begin
                if (at_pos) begin
                    word_next = ctrl_i.value;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign word_o = word_reg;
    assign rd_o   = at_pos ? word_reg : '0;

endmodule

// ----- hw/rtl/oli_ctrl.sv -----
module oli_ctrl
    import oli_pkg::*;
#(
    parameter int unsigned DEPTH = DEPTH_DEFAULT,
    parameter int unsigned CNT_W = $clog2(DEPTH + 1),
    parameter int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              beat_i,
    input  logic [KIND_W-1:0] kind_i,
    input  logic [POS_W-1:0]  pos_i,
    input  logic [DATA_W-1:0] value_i,
    output cell_ctrl_t        cell_ctrl_o,
    output logic [CMP_W-1:0]  cell_pos_o,
    output status_e_t         status_o,
    output logic [CNT_W-1:0]  count_next_o
);

    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CMP_W-1:0] count_ext;
    logic [CMP_W-1:0] pos_ext;
    cell_op_e_t       op;
    status_e_t        status;
    logic             full;

    assign count_ext = CMP_W'(count_reg);
    assign pos_ext   = CMP_W'(pos_i);
    assign full      = (count_ext >= DEPTH_C);

    always_comb begin
        status     = STATUS_DONE;
        op         = CELL_HOLD;
        count_next = count_reg;
        cell_pos_o = pos_ext;
        unique case (kind_e_t'(kind_i))
            KIND_INSERT: begin
                // The position check takes precedence over the full check.
                if (pos_ext > count_ext) begin
                    status = STATUS_RANGE;
                end else if (full) begin
                    status = STATUS_FULL;
                end else begin
                    op         = CELL_SHIFT_UP;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            KIND_DELETE: begin
                if (pos_ext >= count_ext) begin
                    status = STATUS_RANGE;
                end else begin
                    op         = CELL_SHIFT_DOWN;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            KIND_APPEND: begin
                cell_pos_o = count_ext;
                if (full) begin
                    status = STATUS_FULL;
                end else begin
                    op         = CELL_WRITE;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            KIND_OVERWRITE: begin
                if (pos_ext >= count_ext) begin
                    status = STATUS_RANGE;
                end else begin
                    op = CELL_WRITE;
                end
            end
            KIND_READ: begin
                if (pos_ext >= count_ext) begin
                    status = STATUS_RANGE;
                end
            end
            default: begin
                status = STATUS_RANGE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (beat_i) begin
            count_reg <= count_next;
        end
    end

    assign cell_ctrl_o.op    = beat_i ? op : CELL_HOLD;
    assign cell_ctrl_o.value = value_i;
    assign status_o          = status;
    assign count_next_o      = count_next;

`ifndef SYNTHESIS
    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count exceeds the list depth");

    a_count_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !beat_i |=> $stable(count_reg))
        else $error("entry count changed without a request");

    a_count_reject: assert property (@(posedge aclk) disable iff (!aresetn)
        (beat_i && status != STATUS_DONE) |=> $stable(count_reg))
        else $error("rejected request changed the entry count");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        beat_i |=> (count_reg == $past(count_reg)
                    || count_reg == $past(count_reg) + CNT_W'(1)
                    || count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("entry count moved by more than one");
`endif

endmodule

// ----- hw/rtl/ordered_list_insert_delete.sv -----
// A request beat accepted at one clock edge gives its registered result beat
// on m_* from the next cycle on.
// Throughput: one request per cycle while m_tready is high; every storage
// cell shifts, writes or holds in that same cycle, so the depth does not slow it.
// Reset (aresetn low at a clock edge) empties the list and drops any pending
// result; the word cells themselves are not cleared and need no clearing pass.
module ordered_list_insert_delete
    import oli_pkg::*;
#(
    parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [2:0] kind, [9:3] position, [41:10] value, [47:42] zero.
    input  logic [S_TDATA_W-1:0] s_tdata,

    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [1:0] status, [33:2] read_value, [40:34] entry_count_out, [47:41] zero.
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int unsigned M_PAD_W = M_TDATA_W - M_FIELDS_W;

    // Unpacked request fields.
    logic [KIND_W-1:0] s_kind;
    logic [POS_W-1:0]  s_position;
    logic [DATA_W-1:0] s_value;

    logic              beat;
    cell_ctrl_t        cell_ctrl;
    logic [CMP_W-1:0]  cell_pos;
    status_e_t         status;
    logic [CNT_W-1:0]  count_next;

    // Word held in each cell and each cell's contribution to a read.
    logic [DATA_W-1:0] cell_word [DEPTH];
    logic [DATA_W-1:0] cell_rd   [DEPTH];
    logic [DATA_W-1:0] rd_any;
    logic [DATA_W-1:0] read_value;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TDATA_W-1:0] m_tdata_next;

    assign s_kind     = s_tdata[KIND_W-1:0];
    assign s_position = s_tdata[KIND_W+POS_W-1:KIND_W];
    assign s_value    = s_tdata[KIND_W+POS_W+DATA_W-1:KIND_W+POS_W];

    // The output register frees up in the same cycle its beat is taken, so a
    // new request is accepted whenever the result slot is empty or draining.
    assign s_tready = !m_tvalid_reg || m_tready;
    assign beat     = s_tvalid && s_tready;

    // Request decode, range checks and the entry count.
    oli_ctrl #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W),
        .CMP_W (CMP_W)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .beat_i       (beat),
        .kind_i       (s_kind),
        .pos_i        (s_position),
        .value_i      (s_value),
        .cell_ctrl_o  (cell_ctrl),
        .cell_pos_o   (cell_pos),
        .status_o     (status),
        .count_next_o (count_next)
    );

    // Row of storage cells. Cell i holds list entry i. Each cell sees its
    // lower and upper neighbor so that an insert or a delete moves the whole
    // tail of the list by one place in the same cycle. The ends of the row
    // see their own word: the first cell never selects it and the last cell keeps its word on a delete.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [DATA_W-1:0] left_word;
        logic [DATA_W-1:0] right_word;

        if (i == 0) begin : g_first
            assign left_word = cell_word[i];
        end else begin : g_left
            assign left_word = cell_word[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign right_word = cell_word[i];
        end else begin : g_right
            assign right_word = cell_word[i+1];
        end

        oli_cell #(
            .IDX   (i),
            .CMP_W (CMP_W)
        ) u_cell (
            .aclk    (aclk),
            .ctrl_i  (cell_ctrl),
            .pos_i   (cell_pos),
            .left_i  (left_word),
            .right_i (right_word),
            .word_o  (cell_word[i]),
            .rd_o    (cell_rd[i])
        );
    end

    // At most one cell matches the position, so an OR of all cell outputs
    // acts as the read multiplexer.
    always_comb begin
        rd_any = '0;
        for (int unsigned i = 0; i < DEPTH; i++) begin
            rd_any = rd_any | cell_rd[i];
        end
    end

    // A read reports a word only when it succeeded; every other result
    // carries zero in that field.
    assign read_value = (s_kind == KIND_READ && status == STATUS_DONE) ? rd_any : '0;

    assign m_tdata_next = {{M_PAD_W{1'b0}},
                           COUNT_OUT_W'(count_next),
                           read_value,
                           status};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (beat) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (beat) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result was lost or overwritten");

    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        beat |=> m_tvalid)
        else $error("accepted request produced no result");

    a_read_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (beat && s_kind != KIND_READ) |=> (m_tdata[DATA_W+STATUS_W-1:STATUS_W] == '0))
        else $error("non-read request reported a nonzero read value");
`endif

endmodule

// ----- tb/ordered_list_checker.sv -----
module ordered_list_checker
    import oli_pkg::*;
#(
    parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    // [2:0] kind, [9:3] position, [41:10] value, [47:42] zero.
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    // [1:0] status, [33:2] read_value, [40:34] entry_count_out, [47:41] zero.
    input  logic [M_TDATA_W-1:0] m_tdata,
    output int unsigned          fail_count,
    output int unsigned          replies_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        status_e_t               status;
        logic [DATA_W-1:0]       read_value;
        logic [COUNT_OUT_W-1:0]  entry_count;
    } list_reply_t;

    // Shadow copy of the list, updated as each request beat is accepted.
    logic [DATA_W-1:0] shadow_words [DEPTH];
    int unsigned       shadow_len;
    list_reply_t       owed_replies [$];

    initial fail_count = 0;
    initial replies_owed = 0;

    task automatic report_mismatch(input string msg);
        if (fail_count < 100) begin
            $display("%0t ns: mismatch: %s", $time, msg);
        end
        fail_count++;
    endtask

    // Applies one request to the shadow list and returns the reply it must produce.
    function automatic list_reply_t apply_list_request(input logic [S_TDATA_W-1:0] beat);
        logic [KIND_W-1:0]  kind;
        int unsigned        pos;
        logic [DATA_W-1:0]  word;
        list_reply_t        reply;
        int unsigned        i;
        kind = beat[KIND_W-1:0];
        pos = beat[KIND_W +: POS_W];
        word = beat[KIND_W + POS_W +: DATA_W];
        reply.status = STATUS_DONE;
        reply.read_value = '0;
        case (kind)
            KIND_INSERT: begin
                if (pos > shadow_len) begin
                    reply.status = STATUS_RANGE;
                end else if (shadow_len >= DEPTH) begin
                    reply.status = STATUS_FULL;
                end else begin
                    for (i = shadow_len; i > pos; i--) begin
                        shadow_words[i] = shadow_words[i-1];
                    end
                    shadow_words[pos] = word;
                    shadow_len++;
                end
            end
            KIND_DELETE: begin
                if (pos >= shadow_len) begin
                    reply.status = STATUS_RANGE;
                end else begin
                    for (i = pos; i + 1 < shadow_len; i++) begin
                        shadow_words[i] = shadow_words[i+1];
                    end
                    shadow_len--;
                end
            end
            KIND_APPEND: begin
                if (shadow_len >= DEPTH) begin
                    reply.status = STATUS_FULL;
                end else begin
                    shadow_words[shadow_len] = word;
                    shadow_len++;
                end
            end
            KIND_OVERWRITE: begin
                if (pos >= shadow_len) begin
                    reply.status = STATUS_RANGE;
                end else begin
                    shadow_words[pos] = word;
                end
            end
            KIND_READ: begin
                if (pos >= shadow_len) begin
                    reply.status = STATUS_RANGE;
                end else begin
                    reply.read_value = shadow_words[pos];
                end
            end
            default: begin
                reply.status = STATUS_RANGE;
            end
        endcase
        reply.entry_count = shadow_len[COUNT_OUT_W-1:0];
        return reply;
    endfunction

    always @(posedge aclk) begin : watch_channels
        list_reply_t            want;
        logic [STATUS_W-1:0]    got_status;
        logic [DATA_W-1:0]      got_value;
        logic [COUNT_OUT_W-1:0] got_count;
        if (!aresetn) begin
            shadow_len = 0;
            owed_replies.delete();
            replies_owed <= 0;
        end else begin
            // The request is booked before the reply is taken, so the oldest entry is
            // always the one that the reply belongs to.
            if (s_tvalid && s_tready) begin
                owed_replies.push_back(apply_list_request(s_tdata));
            end
            if (m_tvalid && m_tready) begin
                got_status = m_tdata[STATUS_W-1:0];
                got_value = m_tdata[STATUS_W +: DATA_W];
                got_count = m_tdata[STATUS_W + DATA_W +: COUNT_OUT_W];
                if (owed_replies.size() == 0) begin
                    report_mismatch("result beat arrived with no request waiting");
                end else begin
                    want = owed_replies.pop_front();
                    if (got_status !== want.status) begin
                        report_mismatch($sformatf("status: got %0d, expected %0d",
                                                  got_status, want.status));
                    end
                    if (got_value !== want.read_value) begin
                        report_mismatch($sformatf("read_value: got %h, expected %h",
                                                  got_value, want.read_value));
                    end
                    if (got_count !== want.entry_count) begin
                        report_mismatch($sformatf("entry_count_out: got %0d, expected %0d",
                                                  got_count, want.entry_count));
                    end
                end
            end
            replies_owed <= owed_replies.size();
        end
    end

endmodule

// ----- tb/tb_ordered_list_insert_delete.sv -----
module tb_ordered_list_insert_delete;
    import oli_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LIST_DEPTH      = DEPTH_DEFAULT;
    localparam int unsigned RANDOM_BEATS    = 530;
    localparam int unsigned HOLD_OFF_CYCLES = 200;
    localparam int unsigned SETTLE_CYCLES   = 8;
    localparam int unsigned POS_MAX         = (1 << POS_W) - 1;
    localparam int unsigned KIND_MAX        = (1 << KIND_W) - 1;

    // How the random requests of one phase lean.
    typedef enum int {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIX
    } phase_mode_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // [2:0] kind, [9:3] position, [41:10] value, [47:42] zero.
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // [1:0] status, [33:2] read_value, [40:34] entry_count_out, [47:41] zero.
    logic [M_TDATA_W-1:0] m_tdata;
    int unsigned          fail_count;
    int unsigned          replies_owed;

    // Idling switches for each side and the request for one long receiver hold-off.
    bit                   tx_idle_on = 1'b1;
    bit                   rx_idle_on = 1'b1;
    bit                   hold_off_request = 1'b0;

    // Entry count as the stimulus sees it; used to aim positions at legal slots and to see when the list is full.
    int unsigned          list_len = 0;
    int unsigned          beats_sent = 0;

    ordered_list_insert_delete #(
        .DEPTH(LIST_DEPTH)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    ordered_list_checker #(
        .DEPTH(LIST_DEPTH)
    ) list_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .replies_owed(replies_owed)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Watchdog. Ends the run with a failure if the stimulus has not finished first.
    initial begin
        #1_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Receiver side. Exactly one assignment to m_tready per clock edge. A hold-off
    // request from the stimulus keeps m_tready low so the block backs up and has
    // to stall its input.
    initial begin : result_sink
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (hold_off_request) begin
                hold_off_request = 1'b0;
                hold_left = HOLD_OFF_CYCLES - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !(rx_idle_on && $urandom_range(99) < 28);
            end
        end
    end

    // Offers one request beat and returns at the clock edge where it was accepted.
    // Handshake signals are sampled right after the edge, before any register
    // update of that edge has landed, so they show the values the block saw.
    task automatic issue(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                         input logic [DATA_W-1:0] word);
        while (tx_idle_on && $urandom_range(99) < 28) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(S_TDATA_W - S_FIELDS_W){1'b0}}, word, pos, kind};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        case (kind)
            KIND_INSERT: if (pos <= list_len && list_len < LIST_DEPTH) list_len++;
            KIND_APPEND: if (list_len < LIST_DEPTH) list_len++;
            KIND_DELETE: if (pos < list_len) list_len--;
            default: ;
        endcase
    endtask

    // Stops offering and waits until the checker has seen every reply it is owed.
    // The first edge is always waited out so a request accepted at the last edge is
    // already booked when the count is read.
    task automatic wait_for_replies();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (replies_owed != 0) @(posedge aclk);
    endtask

    // Mostly a legal slot for the current length, with the last legal slot, the first
    // illegal one and anything the field can carry mixed in.
    function automatic logic [POS_W-1:0] pick_slot(input bit for_insert);
        int unsigned top_slot;
        if (list_len == 0 && !for_insert) begin
            return POS_W'($urandom_range(POS_MAX));
        end
        top_slot = for_insert ? list_len : list_len - 1;
        case ($urandom_range(9))
            0:       return POS_W'($urandom_range(POS_MAX));
            1:       return POS_W'(top_slot);
            2:       return POS_W'(top_slot + 1);
            default: return POS_W'($urandom_range(top_slot));
        endcase
    endfunction

    // Random words with the sign extremes, zero and all ones showing up often.
    function automatic logic [DATA_W-1:0] pick_word();
        case ($urandom_range(7))
            0:       return {1'b1, {(DATA_W-1){1'b0}}};
            1:       return {1'b0, {(DATA_W-1){1'b1}}};
            2:       return '1;
            3:       return '0;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    // One random request shaped by the phase mode. The checkpoints along the way
    // switch idling off for a stretch, trigger the long receiver hold-off while
    // requests keep coming, and once let the pipeline run dry.
    task automatic random_beat(input phase_mode_t mode);
        int unsigned roll;
        case (beats_sent)
            150: begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            250: begin
                tx_idle_on = 1'b1;
                rx_idle_on = 1'b1;
            end
            300: hold_off_request = 1'b1;
            400: wait_for_replies();
            default: ;
        endcase
        beats_sent++;
        roll = $urandom_range(99);
        if (roll < 12) begin
            // Noise: any kind, including the unused codes, at any position.
            issue(KIND_W'($urandom_range(KIND_MAX)), POS_W'($urandom_range(POS_MAX)),
                  DATA_W'($urandom));
        end else begin
            case (mode)
                MODE_FILL: begin
                    if (roll < 57)      issue(KIND_APPEND, pick_slot(1'b1), pick_word());
                    else if (roll < 82) issue(KIND_INSERT, pick_slot(1'b1), pick_word());
                    else if (roll < 92) issue(KIND_READ, pick_slot(1'b0), pick_word());
                    else                issue(KIND_OVERWRITE, pick_slot(1'b0), pick_word());
                end
                MODE_DRAIN: begin
                    if (roll < 60)      issue(KIND_DELETE, pick_slot(1'b0), pick_word());
                    else if (roll < 75) issue(KIND_READ, pick_slot(1'b0), pick_word());
                    else if (roll < 85) issue(KIND_OVERWRITE, pick_slot(1'b0), pick_word());
                    else if (roll < 92) issue(KIND_INSERT, pick_slot(1'b1), pick_word());
                    else                issue(KIND_APPEND, pick_slot(1'b1), pick_word());
                end
                default: begin
                    case ($urandom_range(4))
                        0: issue(KIND_INSERT, pick_slot(1'b1), pick_word());
                        1: issue(KIND_DELETE, pick_slot(1'b0), pick_word());
                        2: issue(KIND_APPEND, pick_slot(1'b1), pick_word());
                        3: issue(KIND_OVERWRITE, pick_slot(1'b0), pick_word());
                        default: issue(KIND_READ, pick_slot(1'b0), pick_word());
                    endcase
                end
            endcase
        end
    endtask

    initial begin : stimulus
        int unsigned kind_code;
        int unsigned phase;
        int unsigned span;
        int unsigned n;
        phase_mode_t mode;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. Every access to an empty list must be rejected, including an
        // insert past the end.
        issue(KIND_READ, POS_W'(0), '0);
        issue(KIND_DELETE, POS_W'(0), '0);
        issue(KIND_OVERWRITE, POS_W'(0), '1);
        issue(KIND_INSERT, POS_W'(1), '1);
        // Build max, 0, min, -1 using an append and inserts at the head, the middle and the end.
        issue(KIND_APPEND, POS_W'(0), {1'b1, {(DATA_W-1){1'b0}}});
        issue(KIND_INSERT, POS_W'(0), {1'b0, {(DATA_W-1){1'b1}}});
        issue(KIND_INSERT, POS_W'(2), '1);
        issue(KIND_INSERT, POS_W'(1), '0);
        for (n = 0; n < 5; n++) begin
            // The fifth read lands exactly on the count and is out of range.
            issue(KIND_READ, POS_W'(n), '0);
        end
        issue(KIND_OVERWRITE, POS_W'(3), 32'h5555_5555);
        // Delete the first and then the last entry.
        issue(KIND_DELETE, POS_W'(0), '0);
        issue(KIND_DELETE, POS_W'(2), '0);
        issue(KIND_READ, POS_W'(1), '0);
        // Kind codes past the last defined one do nothing even at a legal position.
        for (kind_code = KIND_READ + 1; kind_code <= KIND_MAX; kind_code++) begin
            issue(KIND_W'(kind_code), POS_W'(0), '1);
        end
        issue(KIND_W'(KIND_MAX), POS_W'(POS_MAX), '1);
        issue(KIND_READ, POS_W'(POS_MAX), '0);
        issue(KIND_APPEND, POS_W'(POS_MAX), 32'hA5A5_5A5A);
        wait_for_replies();

        // Random part, in phases. The first phase always fills the list to the top
        // and then keeps pushing against the full list; later phases pick a mode.
        phase = 0;
        while (beats_sent < RANDOM_BEATS) begin
            mode = (phase == 0) ? MODE_FILL : phase_mode_t'($urandom_range(2));
            if (mode == MODE_FILL) begin
                while (list_len < LIST_DEPTH) random_beat(MODE_FILL);
                for (n = 0; n < 8; n++) random_beat(MODE_FILL);
            end else begin
                span = $urandom_range(15, 50);
                for (n = 0; n < span && beats_sent < RANDOM_BEATS; n++) begin
                    random_beat(mode);
                end
            end
            phase++;
        end

        // Let every reply arrive, then keep watching for stray result beats before the verdict.
        wait_for_replies();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
